FILE: hw/rtl/pswq_pkg.sv
// Package for the priority send window queues: depths, widths, op codes, types.
// No dependencies.
`default_nettype none
package pswq_pkg;
   localparam int HighDepthDef   = 128;
   localparam int NormalDepthDef = 512;
   localparam int LowDepthDef    = 512;

   localparam int OpW    = 3;
   localparam int IdW    = 32;
   localparam int TimeW  = 32;
   localparam int CountW = 11;
   localparam int AgeW   = 16;
   localparam int CsrIdxW = 2;
   localparam int CsrDataW = 16;

   localparam logic [OpW-1:0] OP_PUT    = 3'd0;
   localparam logic [OpW-1:0] OP_ACK    = 3'd1;
   localparam logic [OpW-1:0] OP_SWEEP  = 3'd2;
   localparam logic [OpW-1:0] OP_UPDATE = 3'd3;
   localparam logic [OpW-1:0] OP_FETCH  = 3'd4;

   localparam logic [CsrIdxW-1:0] CSR_WINDOW = 2'd0;
   localparam logic [CsrIdxW-1:0] CSR_MOVE   = 2'd1;
   localparam logic [CsrIdxW-1:0] CSR_AGE    = 2'd2;

   localparam logic [1:0] PHASE_STORED   = 2'd0;
   localparam logic [1:0] PHASE_SENT     = 2'd1;
   localparam logic [1:0] PHASE_FINISHED = 2'd2;

   typedef struct packed {
      logic [OpW-1:0]  op;
      logic [1:0]      priority_req;
      logic [IdW-1:0]  packet_id;
      logic [TimeW-1:0] now;
   } req_type;

   typedef struct packed {
      logic            accepted;
      logic [IdW-1:0]  sent_id;
      logic [1:0]      sent_class;
      logic [CountW-1:0] moved_count;
      logic [7:0]      free_high;
      logic [9:0]      free_normal;
      logic [9:0]      free_low;
   } rsp_type;

   typedef struct packed {
      logic [CsrIdxW-1:0]  index;
      logic [CsrDataW-1:0] data;
   } csr_type;
endpackage
`default_nettype wire

FILE: hw/rtl/pswq_if.sv
// Valid/ready channel interface carrying one payload word.
// Depends on nothing; the payload type is a parameter.
`default_nettype none
interface pswq_if #(parameter type payload_type = logic) ();
   logic        valid;
   logic        ready;
   payload_type payload;
   modport source (output valid, output payload, input ready);
   modport sink   (input valid, input payload, output ready);
endinterface
`default_nettype wire

FILE: hw/rtl/pswq_mem.sv
// Entry store: id, time and phase per slot, one write and one registered read.
// Depends on pswq_pkg.
`default_nettype none
module pswq_mem #(
   parameter int Depth = 1152,
   parameter int AddrW = 11
) (
   input  wire logic                     clock,
   input  wire logic                     wr_en,
   input  wire logic [AddrW-1:0]         wr_addr,
   input  wire logic [pswq_pkg::IdW-1:0] wr_id,
   input  wire logic [pswq_pkg::TimeW-1:0] wr_time,
   input  wire logic [1:0]               wr_phase,
   input  wire logic                     wr_phase_only,
   input  wire logic [AddrW-1:0]         rd_addr,
   output logic [pswq_pkg::IdW-1:0]      rd_id,
   output logic [pswq_pkg::TimeW-1:0]    rd_time
);
   import pswq_pkg::*;
   logic [IdW-1:0]   id_mem   [Depth];
   logic [TimeW-1:0] time_mem [Depth];
   logic [1:0]       phase_mem [Depth];

   // Id and time are written by a put; the phase by every write.
   always_ff @(posedge clock) begin
      if (wr_en) begin
         if (!wr_phase_only) begin
            id_mem[wr_addr]   <= wr_id;
            time_mem[wr_addr] <= wr_time;
         end
         phase_mem[wr_addr] <= wr_phase;
      end
      rd_id   <= id_mem[rd_addr];
      rd_time <= time_mem[rd_addr];
   end
endmodule
`default_nettype wire

FILE: hw/rtl/priority_send_window_queues.sv
// Top level of the priority send window queues. Depends on pswq_pkg, pswq_if, pswq_mem.
// Holds the index registers, the sequencer and the response register.
//
// One request word yields one response word. A put or a fetch passes through S_UPDATE
// and S_DONE before its response is registered. A window update releases one entry
// per step in S_UPDATE, up to the smaller of the move limit and the free window room.
// An acknowledge or a sweep walks the entry memory one slot at a time. Each slot is
// read in S_READ and checked in S_CHECK. At the end of each queue the walk moves on
// to the next queue. Requests are handled one at a time. A new request is taken
// only once the previous response has left the output register, or leaves it in
// the same cycle.
`default_nettype none
module priority_send_window_queues #(
   parameter int HighDepth   = pswq_pkg::HighDepthDef,
   parameter int NormalDepth = pswq_pkg::NormalDepthDef,
   parameter int LowDepth    = pswq_pkg::LowDepthDef
) (
   input wire logic clock,
   input wire logic reset,
   pswq_if.sink   req,
   pswq_if.source rsp,
   pswq_if.sink   csr
);
   import pswq_pkg::*;

   localparam int Total = HighDepth + NormalDepth + LowDepth;
   localparam int AddrW = $clog2(Total);
   localparam int IdxW  = 13;

   typedef enum logic [2:0] {
      S_IDLE, S_READ, S_CHECK, S_UPDATE, S_DONE
   } state_type;

   state_type state_ff;
   logic [IdxW-1:0] beg_ff [3];
   logic [IdxW-1:0] snd_ff [3];
   logic [IdxW-1:0] rel_ff [3];
   logic [IdxW-1:0] wr_ff  [3];
   logic [CountW-1:0] win_ff, mov_ff;
   logic [AgeW-1:0]   age_ff;
   req_type req_ff;
   logic [1:0] q_ff;
   logic [IdxW-1:0] cur_ff;
   logic [CountW-1:0] room_ff, moved_ff;
   logic acc_ff, out_valid_ff;
   logic [IdW-1:0] sid_ff;
   logic [1:0] scls_ff;

   function automatic logic [IdxW-1:0] qdepth(input logic [1:0] q);
      case (q)
         2'd0:    qdepth = IdxW'(HighDepth);
         2'd1:    qdepth = IdxW'(NormalDepth);
         default: qdepth = IdxW'(LowDepth);
      endcase
   endfunction

   function automatic logic [IdxW-1:0] qbase(input logic [1:0] q);
      case (q)
         2'd0:    qbase = '0;
         2'd1:    qbase = IdxW'(HighDepth);
         default: qbase = IdxW'(HighDepth + NormalDepth);
      endcase
   endfunction

   function automatic logic [IdxW-1:0] nxt(input logic [1:0] q, input logic [IdxW-1:0] i);
      nxt = (i + 1'b1 == qdepth(q)) ? '0 : i + 1'b1;
   endfunction

   logic [IdxW-1:0] inwin [3];
   always_comb begin
      for (int k = 0; k < 3; k++) begin
         inwin[k] = (rel_ff[k] >= beg_ff[k]) ? rel_ff[k] - beg_ff[k]
                    : rel_ff[k] + qdepth(2'(k)) - beg_ff[k];
      end
   end
   logic [IdxW-1:0] used;
   assign used = inwin[0] + inwin[1] + inwin[2];

   // Memory port control.
   logic mem_we, mem_phase_only;
   logic [AddrW-1:0] mem_waddr, mem_raddr;
   logic [1:0] mem_wphase;
   logic [IdW-1:0] rd_id;
   logic [TimeW-1:0] rd_time;

   pswq_mem #(.Depth(Total), .AddrW(AddrW)) u_mem (
      .clock, .wr_en(mem_we), .wr_addr(mem_waddr), .wr_id(req_ff.packet_id),
      .wr_time(req_ff.now), .wr_phase(mem_wphase), .wr_phase_only(mem_phase_only),
      .rd_addr(mem_raddr), .rd_id, .rd_time
   );

   logic [1:0] put_q;
   assign put_q = (req_ff.priority_req <= 2'd1) ? 2'd0
                  : (req_ff.priority_req == 2'd2) ? 2'd1 : 2'd2;

   logic [1:0] fetch_q, upd_q;
   logic fetch_any, upd_any;
   always_comb begin
      fetch_any = 1'b1; fetch_q = 2'd0;
      if (snd_ff[0] != rel_ff[0]) fetch_q = 2'd0;
      else if (snd_ff[1] != rel_ff[1]) fetch_q = 2'd1;
      else if (snd_ff[2] != rel_ff[2]) fetch_q = 2'd2;
      else fetch_any = 1'b0;
      upd_any = 1'b1; upd_q = 2'd0;
      if (rel_ff[0] != wr_ff[0]) upd_q = 2'd0;
      else if (rel_ff[1] != wr_ff[1]) upd_q = 2'd1;
      else if (rel_ff[2] != wr_ff[2]) upd_q = 2'd2;
      else upd_any = 1'b0;
   end

   logic [TimeW-1:0] age_diff;
   assign age_diff = req_ff.now - rd_time;

   always_comb begin
      mem_we = 1'b0; mem_phase_only = 1'b1; mem_wphase = PHASE_STORED;
      mem_waddr = AddrW'(qbase(q_ff) + cur_ff);
      mem_raddr = AddrW'(qbase(q_ff) + cur_ff);
      if (state_ff == S_UPDATE) begin
         if (req_ff.op == OP_PUT && beg_ff[put_q] != nxt(put_q, wr_ff[put_q])) begin
            mem_we = 1'b1; mem_phase_only = 1'b0;
            mem_waddr = AddrW'(qbase(put_q) + wr_ff[put_q]);
         end else if (req_ff.op == OP_FETCH && fetch_any) begin
            mem_we = 1'b1; mem_wphase = PHASE_SENT;
            mem_waddr = AddrW'(qbase(fetch_q) + snd_ff[fetch_q]);
         end
         mem_raddr = AddrW'(qbase(fetch_q) + snd_ff[fetch_q]);
      end else if (state_ff == S_CHECK && req_ff.op == OP_ACK && rd_id == req_ff.packet_id) begin
         mem_we = 1'b1; mem_wphase = PHASE_FINISHED;
      end
   end

   assign req.ready = (state_ff == S_IDLE) && (!out_valid_ff || rsp.ready);
   assign csr.ready = 1'b1;
   assign rsp.valid = out_valid_ff;
   always_comb begin
      rsp.payload.accepted    = acc_ff;
      rsp.payload.sent_id     = sid_ff;
      rsp.payload.sent_class  = scls_ff;
      rsp.payload.moved_count = moved_ff;
      rsp.payload.free_high   = 8'(qdepth(2'd0) - inwin[0]);
      rsp.payload.free_normal = 10'(qdepth(2'd1) - inwin[1]);
      rsp.payload.free_low    = 10'(qdepth(2'd2) - inwin[2]);
   end

   // Sequencer: walks the memory for acknowledge and sweep, steps updates, puts and fetches; takes CSR writes.
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE; out_valid_ff <= 1'b0;
         win_ff <= CountW'(16); mov_ff <= CountW'(16); age_ff <= AgeW'(60);
         for (int k = 0; k < 3; k++) begin
            beg_ff[k] <= '0; snd_ff[k] <= '0; rel_ff[k] <= '0; wr_ff[k] <= '0;
         end
      end else begin
         if (csr.valid) begin
            case (csr.payload.index)
               CSR_WINDOW: win_ff <= CountW'(csr.payload.data);
               CSR_MOVE:   mov_ff <= CountW'(csr.payload.data);
               CSR_AGE:    age_ff <= csr.payload.data;
               default: ;
            endcase
         end
         if (rsp.valid && rsp.ready) out_valid_ff <= 1'b0;
         case (state_ff)
            S_IDLE: begin
               if (req.valid && req.ready) begin
                  req_ff <= req.payload;
                  acc_ff <= 1'b0; sid_ff <= '0; scls_ff <= '0; moved_ff <= '0;
                  q_ff <= 2'd0; cur_ff <= beg_ff[0];
                  room_ff <= (used < IdxW'(win_ff))
                     ? ((IdxW'(win_ff) - used > IdxW'(mov_ff)) ? mov_ff
                        : CountW'(IdxW'(win_ff) - used)) : '0;
                  if (req.payload.op == OP_ACK || req.payload.op == OP_SWEEP)
                     state_ff <= S_READ;
                  else state_ff <= S_UPDATE;
               end
            end
            S_READ: begin
               if (cur_ff == snd_ff[q_ff]) begin
                  if (q_ff == 2'd2) state_ff <= S_DONE;
                  else begin
                     q_ff <= q_ff + 2'd1; cur_ff <= beg_ff[q_ff + 2'd1];
                  end
               end else state_ff <= S_CHECK;
            end
            S_CHECK: begin
               if (req_ff.op == OP_ACK) begin
                  if (rd_id == req_ff.packet_id) begin
                     acc_ff <= 1'b1;
                     if (cur_ff == beg_ff[q_ff]) beg_ff[q_ff] <= nxt(q_ff, cur_ff);
                     state_ff <= S_DONE;
                  end else begin
                     cur_ff <= nxt(q_ff, cur_ff); state_ff <= S_READ;
                  end
               end else begin
                  if (age_diff > TimeW'(age_ff)) begin
                     beg_ff[q_ff] <= nxt(q_ff, cur_ff);
                     cur_ff <= nxt(q_ff, cur_ff);
                     moved_ff <= moved_ff + 1'b1;
                     state_ff <= S_READ;
                  end else if (q_ff == 2'd2) state_ff <= S_DONE;
                  else begin
                     q_ff <= q_ff + 2'd1; cur_ff <= beg_ff[q_ff + 2'd1];
                     state_ff <= S_READ;
                  end
               end
            end
            S_UPDATE: begin
               case (req_ff.op)
                  OP_PUT: begin
                     if (beg_ff[put_q] != nxt(put_q, wr_ff[put_q])) begin
                        wr_ff[put_q] <= nxt(put_q, wr_ff[put_q]);
                        acc_ff <= 1'b1;
                     end
                     state_ff <= S_DONE;
                  end
                  OP_FETCH: begin
                     // Read data for the fetched slot arrives next cycle.
                     if (fetch_any) begin
                        snd_ff[fetch_q] <= nxt(fetch_q, snd_ff[fetch_q]);
                        scls_ff <= fetch_q; acc_ff <= 1'b1; q_ff <= 2'd3;
                     end
                     state_ff <= S_DONE;
                  end
                  OP_UPDATE: begin
                     if (room_ff != '0 && upd_any) begin
                        rel_ff[upd_q] <= nxt(upd_q, rel_ff[upd_q]);
                        moved_ff <= moved_ff + 1'b1;
                        room_ff <= room_ff - 1'b1;
                     end else state_ff <= S_DONE;
                  end
                  default: state_ff <= S_DONE;
               endcase
            end
            S_DONE: begin
               if (req_ff.op == OP_FETCH && q_ff == 2'd3) sid_ff <= rd_id;
               if (!out_valid_ff || rsp.ready) begin
                  out_valid_ff <= 1'b1; state_ff <= S_IDLE;
               end
            end
            default: state_ff <= S_IDLE;
         endcase
      end
   end
endmodule
`default_nettype wire
